[rtl/ffra_pkg.sv]
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared word types and codes for the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  // action codes
  localparam logic [1:0] ACT_ALLOC    = 2'd0;
  localparam logic [1:0] ACT_FREE     = 2'd1;
  localparam logic [1:0] ACT_FREE_TAG = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_MEM = 2'd1;
  localparam logic [1:0] ST_BAD_ID = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_REGION_START  = 2'd0;
  localparam logic [1:0] CFG_REGION_LENGTH = 2'd1;
  localparam logic [1:0] CFG_GRANULE_LOG2  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] request_size;
    logic [31:0] target_id;
    logic [15:0] owner_tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  granted_id;
    logic [31:0] granted_offset;
  } out_word_t;

endpackage

[rtl/ffra_desc_mem.sv]
// ----------------------------------------------------------------------------
// ffra_desc_mem
// Descriptor table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffra_desc_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/first_fit_region_allocator_core.sv]
// Allocate walks the list one descriptor per cycle and, on a split, writes the
// spare, the successor's back link and the chosen block; free checks the id and
// owner, then releases the block and joins it with free neighbours; free-by-owner
// walks the list and releases each match. One word at a time; the descriptor
// memory sets the pace. Reset and every write to the three configuration registers
// start a clearing pass that rebuilds the table; no word is accepted until it ends.
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// First-fit allocator over one address range with an address-ordered linked
// descriptor list, splitting on allocate and coalescing on free.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_core
  import ffra_pkg::*;
#(
  parameter int DESCRIPTORS = 64,
  parameter int OWNER_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int IW = $clog2(DESCRIPTORS);
  localparam int LW = $clog2(DESCRIPTORS + 1);
  localparam int SW = $clog2(DESCRIPTORS + 2);

  typedef struct packed {
    logic [31:0]           base;
    logic [31:0]           size;
    logic                  in_use;
    logic [OWNER_BITS-1:0] owner;
    logic [LW-1:0]         next;
    logic [LW-1:0]         prev;
  } desc_t;

  localparam int RW = $bits(desc_t);

  typedef enum logic [17:0] {
    S_CLR     = 18'h00001,
    S_IDLE    = 18'h00002,
    S_A_CHK   = 18'h00004,
    S_A_SP    = 18'h00008,
    S_A_NX    = 18'h00010,
    S_A_WC    = 18'h00020,
    S_F_CHK   = 18'h00040,
    S_REL     = 18'h00080,
    S_R_PV    = 18'h00100,
    S_R_N0    = 18'h00200,
    S_R_NX    = 18'h00400,
    S_J0      = 18'h00800,
    S_J1      = 18'h01000,
    S_J2      = 18'h02000,
    S_J3      = 18'h04000,
    S_REL_END = 18'h08000,
    S_T_CHK   = 18'h10000,
    S_DONE    = 18'h20000
  } state_t;

  // link (index + 1, zero is none) to table index
  function automatic logic [IW-1:0] lidx(input logic [LW-1:0] l);
    logic [LW-1:0] t;
    t = l - LW'(1);
    return t[IW-1:0];
  endfunction

  // table index to link
  function automatic logic [LW-1:0] mklink(input logic [IW-1:0] i);
    return LW'(i) + LW'(1);
  endfunction

  state_t                state_r, state_nxt;
  logic [31:0]           start_r, start_nxt;
  logic [31:0]           length_r, length_nxt;
  logic [4:0]            gran_r, gran_nxt;
  logic [IW-1:0]         clr_idx_r, clr_idx_nxt;
  logic [LW-1:0]         spare_head_r, spare_head_nxt;
  logic [IW-1:0]         cur_r, cur_nxt;
  logic [SW-1:0]         steps_r, steps_nxt;
  desc_t                 k_r, k_nxt;
  logic [IW-1:0]         kidx_r, kidx_nxt;
  desc_t                 n_r, n_nxt;
  logic [IW-1:0]         nidx_r, nidx_nxt;
  logic [IW-1:0]         s_r, s_nxt;
  logic [31:0]           sz_r, sz_nxt;
  logic [OWNER_BITS-1:0] tag_r, tag_nxt;
  logic                  ret_tag_r, ret_tag_nxt;
  logic                  jret_r, jret_nxt;
  out_word_t             res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_r, out_nxt;

  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  desc_t                 mem_wdata;
  logic [IW-1:0]         mem_raddr;
  desc_t                 mem_q;

  logic                  in_fire;
  logic [32:0]           g_mask;
  logic [32:0]           sz_full;
  logic                  fit;

  ffra_desc_mem #(
    .DEPTH (DESCRIPTORS),
    .WIDTH (RW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // size rounded up to the granule
  assign g_mask  = (33'(1) << gran_r) - 33'(1);
  assign sz_full = ({1'b0, in_word.request_size} + g_mask) & ~g_mask;

  // first-fit test on the descriptor just read
  assign fit = !mem_q.in_use && (mem_q.size >= sz_r);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    start_nxt      = start_r;
    length_nxt     = length_r;
    gran_nxt       = gran_r;
    clr_idx_nxt    = clr_idx_r;
    spare_head_nxt = spare_head_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    k_nxt          = k_r;
    kidx_nxt       = kidx_r;
    n_nxt          = n_r;
    nidx_nxt       = nidx_r;
    s_nxt          = s_r;
    sz_nxt         = sz_r;
    tag_nxt        = tag_r;
    ret_tag_nxt    = ret_tag_r;
    jret_nxt       = jret_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_waddr      = kidx_r;
    mem_wdata      = k_r;
    mem_raddr      = cur_r;

    unique case (state_r)
      S_CLR: begin
        mem_we           = 1'b1;
        mem_waddr        = clr_idx_r;
        mem_wdata        = '0;
        if (clr_idx_r == '0) begin
          mem_wdata.base = start_r;
          mem_wdata.size = length_r;
        end else if (clr_idx_r != IW'(DESCRIPTORS - 1)) begin
          mem_wdata.next = LW'(clr_idx_r) + LW'(2);
        end
        spare_head_nxt   = LW'(2);
        clr_idx_nxt      = clr_idx_r + IW'(1);
        if (clr_idx_r == IW'(DESCRIPTORS - 1)) begin
          state_nxt      = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          tag_nxt   = OWNER_BITS'(in_word.owner_tag);
          sz_nxt    = sz_full[31:0];
          cur_nxt   = '0;
          steps_nxt = '0;
          res_nxt   = '0;
          mem_raddr = '0;
          unique case (in_word.action)
            ACT_ALLOC: begin
              if (sz_full[32]) begin
                res_nxt.status = ST_NO_MEM;
                state_nxt      = S_DONE;
              end else begin
                state_nxt      = S_A_CHK;
              end
            end
            ACT_FREE: begin
              if (in_word.target_id == 32'd0 ||
                  in_word.target_id > 32'(DESCRIPTORS)) begin
                res_nxt.status = ST_BAD_ID;
                state_nxt      = S_DONE;
              end else begin
                kidx_nxt       = IW'(in_word.target_id - 32'd1);
                mem_raddr      = IW'(in_word.target_id - 32'd1);
                state_nxt      = S_F_CHK;
              end
            end
            ACT_FREE_TAG: begin
              state_nxt        = S_T_CHK;
            end
            default: begin
              res_nxt.status   = ST_BAD_ID;
              state_nxt        = S_DONE;
            end
          endcase
        end
      end

      // allocate: walk the list one descriptor a cycle
      S_A_CHK: begin
        if (fit) begin
          if (mem_q.size == sz_r) begin
            mem_we                 = 1'b1;
            mem_waddr              = cur_r;
            mem_wdata              = mem_q;
            mem_wdata.in_use       = 1'b1;
            mem_wdata.owner        = tag_r;
            res_nxt.status         = ST_OK;
            res_nxt.granted_id     = 7'(mklink(cur_r));
            res_nxt.granted_offset = mem_q.base;
            state_nxt              = S_DONE;
          end else if (spare_head_r == '0) begin
            res_nxt.status         = ST_NO_MEM;
            state_nxt              = S_DONE;
          end else begin
            k_nxt                  = mem_q;
            s_nxt                  = lidx(spare_head_r);
            mem_raddr              = lidx(spare_head_r);
            state_nxt              = S_A_SP;
          end
        end else if (mem_q.next == '0 || steps_r >= SW'(DESCRIPTORS)) begin
          res_nxt.status           = ST_NO_MEM;
          state_nxt                = S_DONE;
        end else begin
          steps_nxt                = steps_r + SW'(1);
          cur_nxt                  = lidx(mem_q.next);
          mem_raddr                = lidx(mem_q.next);
        end
      end

      // split: remainder goes into the spare descriptor
      S_A_SP: begin
        spare_head_nxt   = mem_q.next;
        mem_we           = 1'b1;
        mem_waddr        = s_r;
        mem_wdata.base   = k_r.base + sz_r;
        mem_wdata.size   = k_r.size - sz_r;
        mem_wdata.in_use = 1'b0;
        mem_wdata.owner  = mem_q.owner;
        mem_wdata.next   = k_r.next;
        mem_wdata.prev   = mklink(cur_r);
        if (k_r.next != '0) begin
          mem_raddr      = lidx(k_r.next);
          state_nxt      = S_A_NX;
        end else begin
          state_nxt      = S_A_WC;
        end
      end

      S_A_NX: begin
        mem_we         = 1'b1;
        mem_waddr      = lidx(k_r.next);
        mem_wdata      = mem_q;
        mem_wdata.prev = mklink(s_r);
        state_nxt      = S_A_WC;
      end

      S_A_WC: begin
        mem_we                 = 1'b1;
        mem_waddr              = cur_r;
        mem_wdata              = k_r;
        mem_wdata.size         = sz_r;
        mem_wdata.in_use       = 1'b1;
        mem_wdata.owner        = tag_r;
        mem_wdata.next         = mklink(s_r);
        res_nxt.status         = ST_OK;
        res_nxt.granted_id     = 7'(mklink(cur_r));
        res_nxt.granted_offset = k_r.base;
        state_nxt              = S_DONE;
      end

      // free one block: id and owner check
      S_F_CHK: begin
        if (!mem_q.in_use || mem_q.owner != tag_r) begin
          res_nxt.status = ST_BAD_ID;
          state_nxt      = S_DONE;
        end else begin
          k_nxt          = mem_q;
          k_nxt.in_use   = 1'b0;
          ret_tag_nxt    = 1'b0;
          state_nxt      = S_REL;
        end
      end

      // release: mark free, then look at the previous neighbor
      S_REL: begin
        mem_we    = 1'b1;
        mem_waddr = kidx_r;
        mem_wdata = k_r;
        if (k_r.prev != '0) begin
          mem_raddr = lidx(k_r.prev);
          state_nxt = S_R_PV;
        end else begin
          state_nxt = S_R_N0;
        end
      end

      S_R_PV: begin
        if (!mem_q.in_use) begin
          n_nxt     = k_r;
          nidx_nxt  = kidx_r;
          k_nxt     = mem_q;
          kidx_nxt  = lidx(k_r.prev);
          jret_nxt  = 1'b0;
          state_nxt = S_J0;
        end else begin
          state_nxt = S_R_N0;
        end
      end

      S_R_N0: begin
        if (k_r.next != '0) begin
          mem_raddr = lidx(k_r.next);
          state_nxt = S_R_NX;
        end else begin
          state_nxt = S_REL_END;
        end
      end

      S_R_NX: begin
        if (!mem_q.in_use) begin
          n_nxt     = mem_q;
          nidx_nxt  = lidx(k_r.next);
          jret_nxt  = 1'b1;
          state_nxt = S_J0;
        end else begin
          state_nxt = S_REL_END;
        end
      end

      // join with successor: grow, relink, return successor to spares
      S_J0: begin
        k_nxt.size  = k_r.size + n_r.size;
        if (n_r.next != '0) begin
          mem_raddr = lidx(n_r.next);
          state_nxt = S_J1;
        end else begin
          state_nxt = S_J2;
        end
      end

      S_J1: begin
        mem_we         = 1'b1;
        mem_waddr      = lidx(n_r.next);
        mem_wdata      = mem_q;
        mem_wdata.prev = mklink(kidx_r);
        state_nxt      = S_J2;
      end

      S_J2: begin
        mem_we         = 1'b1;
        mem_waddr      = nidx_r;
        mem_wdata      = n_r;
        mem_wdata.next = spare_head_r;
        spare_head_nxt = mklink(nidx_r);
        k_nxt.next     = n_r.next;
        state_nxt      = S_J3;
      end

      S_J3: begin
        mem_we    = 1'b1;
        mem_waddr = kidx_r;
        mem_wdata = k_r;
        state_nxt = jret_r ? S_REL_END : S_R_N0;
      end

      S_REL_END: begin
        if (!ret_tag_r) begin
          res_nxt.status = ST_OK;
          state_nxt      = S_DONE;
        end else if (k_r.next == '0 || steps_r >= SW'(DESCRIPTORS)) begin
          res_nxt.status = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          steps_nxt      = steps_r + SW'(1);
          cur_nxt        = lidx(k_r.next);
          mem_raddr      = lidx(k_r.next);
          state_nxt      = S_T_CHK;
        end
      end

      // free by owner: walk the list, release each match
      S_T_CHK: begin
        if (mem_q.in_use && mem_q.owner == tag_r) begin
          k_nxt          = mem_q;
          k_nxt.in_use   = 1'b0;
          kidx_nxt       = cur_r;
          ret_tag_nxt    = 1'b1;
          state_nxt      = S_REL;
        end else if (mem_q.next == '0 || steps_r >= SW'(DESCRIPTORS)) begin
          res_nxt.status = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          steps_nxt      = steps_r + SW'(1);
          cur_nxt        = lidx(mem_q.next);
          mem_raddr      = lidx(mem_q.next);
        end
      end

      // hand the result word to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLR;
      end
    endcase

    // a write to one of the three configuration registers rebuilds the table
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION_START: begin
          start_nxt   = cfg_wdata;
          state_nxt   = S_CLR;
          clr_idx_nxt = '0;
        end
        CFG_REGION_LENGTH: begin
          length_nxt  = cfg_wdata;
          state_nxt   = S_CLR;
          clr_idx_nxt = '0;
        end
        CFG_GRANULE_LOG2: begin
          gran_nxt    = cfg_wdata[4:0];
          state_nxt   = S_CLR;
          clr_idx_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      start_r     <= '0;
      length_r    <= '0;
      gran_r      <= 5'd12;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      length_r    <= length_nxt;
      gran_r      <= gran_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    spare_head_r <= spare_head_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    k_r          <= k_nxt;
    kidx_r       <= kidx_nxt;
    n_r          <= n_nxt;
    nidx_r       <= nidx_nxt;
    s_r          <= s_nxt;
    sz_r         <= sz_nxt;
    tag_r        <= tag_nxt;
    ret_tag_r    <= ret_tag_nxt;
    jret_r       <= jret_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end

endmodule

[tb/sv/ffra_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffra_checker
// Watches the request and response channels of the region allocator, keeps
// its own descriptor table, predicts every response and compares it.
// ----------------------------------------------------------------------------
module ffra_checker
  import ffra_pkg::*;
#(
  parameter int DESCRIPTORS = 64,
  parameter int OWNER_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count
);

  localparam logic [6:0] NONE = 7'd0;

  // register shadow
  logic [31:0] area_start;
  logic [31:0] area_length;
  logic [4:0]  gran_log2;

  // descriptor table shadow; links hold index + 1, 0 means none
  logic [31:0] rg_base  [DESCRIPTORS];
  logic [31:0] rg_size  [DESCRIPTORS];
  logic        rg_busy  [DESCRIPTORS];
  logic [31:0] rg_owner [DESCRIPTORS];
  logic [6:0]  rg_next  [DESCRIPTORS];
  logic [6:0]  rg_prev  [DESCRIPTORS];
  logic [6:0]  spare_top;

  out_word_t expected_q[$];

  assign pending_count = expected_q.size();

  function automatic int link_to_idx(logic [6:0] lk);
    return (int'(lk) - 1 + DESCRIPTORS) % DESCRIPTORS;
  endfunction

  function automatic void rebuild_table();
    for (int i = 0; i < DESCRIPTORS; i++) begin
      rg_base[i]  = '0;
      rg_size[i]  = '0;
      rg_busy[i]  = 1'b0;
      rg_owner[i] = '0;
      rg_prev[i]  = NONE;
      rg_next[i]  = (i >= 1 && i + 1 < DESCRIPTORS) ? 7'(i + 2) : NONE;
    end
    rg_base[0] = area_start;
    rg_size[0] = area_length;
    spare_top  = 7'd2;
  endfunction

  // merge region k with its successor, successor goes back to the spares
  function automatic void merge_with_next(int k);
    int n;
    if (rg_next[k] == NONE) return;
    n = link_to_idx(rg_next[k]);
    rg_size[k] = rg_size[k] + rg_size[n];
    if (rg_next[n] != NONE) rg_prev[link_to_idx(rg_next[n])] = 7'(k + 1);
    rg_next[k] = rg_next[n];
    rg_next[n] = spare_top;
    spare_top  = 7'(n + 1);
  endfunction

  function automatic int release_region(int k);
    rg_busy[k] = 1'b0;
    if (rg_prev[k] != NONE && !rg_busy[link_to_idx(rg_prev[k])]) begin
      k = link_to_idx(rg_prev[k]);
      merge_with_next(k);
    end
    if (rg_next[k] != NONE && !rg_busy[link_to_idx(rg_next[k])]) merge_with_next(k);
    return k;
  endfunction

  // compute the response to one request word and update the table
  function automatic out_word_t allocate_or_free(in_word_t w);
    out_word_t   r;
    logic [63:0] g, sz;
    logic [31:0] tag, k;
    int cur, steps, s;
    bit found;
    r   = '0;
    tag = 32'(w.owner_tag) & 32'((64'd1 << OWNER_BITS) - 64'd1);
    if (w.action == ACT_ALLOC) begin
      g = 64'd1 << gran_log2;
      sz = (64'(w.request_size) + g - 64'd1) & ~(g - 64'd1);
      cur = 0; steps = 0; found = 0;
      r.status = ST_NO_MEM;
      if (sz <= 64'hFFFF_FFFF) begin
        forever begin
          if (!rg_busy[cur] && 64'(rg_size[cur]) >= sz) begin
            found = 1;
            break;
          end
          steps++;
          if (rg_next[cur] == NONE || steps > DESCRIPTORS) break;
          cur = link_to_idx(rg_next[cur]);
        end
      end
      if (found) begin
        if (sz[31:0] != rg_size[cur]) begin
          if (spare_top == NONE) found = 0;
          else begin
            s = link_to_idx(spare_top);
            spare_top  = rg_next[s];
            rg_next[s] = rg_next[cur];
            rg_prev[s] = 7'(cur + 1);
            rg_busy[s] = 1'b0;
            rg_base[s] = rg_base[cur] + sz[31:0];
            rg_size[s] = rg_size[cur] - sz[31:0];
            if (rg_next[cur] != NONE) rg_prev[link_to_idx(rg_next[cur])] = 7'(s + 1);
            rg_next[cur] = 7'(s + 1);
            rg_size[cur] = sz[31:0];
          end
        end
        if (found) begin
          rg_busy[cur]     = 1'b1;
          rg_owner[cur]    = tag;
          r.status         = ST_OK;
          r.granted_id     = 7'(cur + 1);
          r.granted_offset = rg_base[cur];
        end
      end
    end else if (w.action == ACT_FREE) begin
      k = w.target_id - 32'd1;
      if (k >= DESCRIPTORS || !rg_busy[k] || rg_owner[k] != tag) r.status = ST_BAD_ID;
      else void'(release_region(int'(k)));
    end else if (w.action == ACT_FREE_TAG) begin
      cur = 0; steps = 0;
      forever begin
        if (rg_busy[cur] && rg_owner[cur] == tag) cur = release_region(cur);
        steps++;
        if (rg_next[cur] == NONE || steps > DESCRIPTORS) break;
        cur = link_to_idx(rg_next[cur]);
      end
    end else begin
      r.status = ST_BAD_ID;
    end
    return r;
  endfunction

  // track config writes, requests and responses
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      area_start  = '0;
      area_length = '0;
      gran_log2   = 5'd12;
      rebuild_table();
      expected_q.delete();
      fail_count  = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_REGION_START) begin
          area_start = cfg_wdata;
          rebuild_table();
        end else if (cfg_index == CFG_REGION_LENGTH) begin
          area_length = cfg_wdata;
          rebuild_table();
        end else if (cfg_index == CFG_GRANULE_LOG2) begin
          gran_log2 = cfg_wdata[4:0];
          rebuild_table();
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(allocate_or_free(in_word));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_word);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (want.status !== out_word.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_word.status);
          if (want.granted_id !== out_word.granted_id)
            $display("%0t: granted_id expected %0d actual %0d", $time, want.granted_id,
                     out_word.granted_id);
          if (want.granted_offset !== out_word.granted_offset)
            $display("%0t: granted_offset expected %h actual %h", $time,
                     want.granted_offset, out_word.granted_offset);
          if (want !== out_word) fail_count++;
        end
      end
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives random and directed allocate / free traffic with register changes
// into the region allocator; a side checker predicts and compares responses.
// ----------------------------------------------------------------------------
module tb;
  import ffra_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending_count;
  int          idle_cycles;
  bit          hold_rx;

  first_fit_region_allocator_core DUT (.*);

  ffra_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("first_fit_region_allocator_core: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off while hold_rx is set
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_rx = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      out_stall = 1'b1;
      repeat (gap) @(negedge clk);
      out_stall = 1'b0;
      while (!(out_valid === 1'b1)) @(negedge clk);
      @(posedge clk);
    end
  end

  // valid stays high into the next word when there is no gap
  task automatic send_word(logic [1:0] act, logic [31:0] sz, logic [31:0] id,
                           logic [15:0] tag, bit no_gap = 0);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  <= '{action: act, request_size: sz, target_id: id, owner_tag: tag};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // mostly valid allocate/free traffic over a small set of owners
  task automatic random_traffic(int count);
    logic [1:0]  act;
    logic [31:0] sz;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      act = (r < 50) ? ACT_ALLOC : (r < 85) ? ACT_FREE : (r < 96) ? ACT_FREE_TAG : 2'd3;
      case ($urandom_range(0, 5))
        0: sz = $urandom();
        1: sz = 32'hFFFF_FFFF - $urandom_range(0, 4);
        default: sz = $urandom_range(0, 20000);
      endcase
      send_word(act, sz,
                ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 65)),
                ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_rx   = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty range after reset, then extremes
    send_word(ACT_ALLOC, 32'd0, 32'd0, 16'd0);
    send_word(ACT_ALLOC, 32'd1, 32'd0, 16'd0);
    drain_results();
    write_reg(CFG_REGION_START, 32'hFFFF_F000);
    write_reg(CFG_REGION_LENGTH, 32'h0010_0000);
    write_reg(2'd3, 32'hFFFF_FFFF);
    send_word(ACT_ALLOC, 32'h0000_2000, 32'd0, 16'hFFFF);
    send_word(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0, 16'd1);
    send_word(ACT_ALLOC, 32'd0, 32'd0, 16'd1);
    send_word(ACT_ALLOC, 32'd5000, 32'd0, 16'd2);
    send_word(ACT_FREE, 32'd0, 32'd0, 16'hFFFF);
    send_word(ACT_FREE, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(ACT_FREE, 32'd0, 32'd65, 16'd0);
    send_word(ACT_FREE, 32'd0, 32'd1, 16'd7);
    send_word(ACT_FREE, 32'd0, 32'd1, 16'hFFFF);
    send_word(ACT_FREE, 32'd0, 32'd1, 16'hFFFF);
    send_word(ACT_FREE_TAG, 32'd0, 32'd0, 16'd9);
    send_word(ACT_FREE_TAG, 32'd0, 32'd0, 16'd2);
    send_word(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    // run out of spare descriptors
    for (int i = 0; i < 66; i++) send_word(ACT_ALLOC, 32'd1, 32'd0, 16'd3, 1);
    send_word(ACT_FREE_TAG, 32'd0, 32'd0, 16'd3);
    drain_results();

    // granule 0 then granule 31 for rounding overflow
    write_reg(CFG_GRANULE_LOG2, 32'd0);
    write_reg(CFG_REGION_START, 32'd0);
    write_reg(CFG_REGION_LENGTH, 32'hFFFF_FFFF);
    random_traffic(120);
    drain_results();
    write_reg(CFG_GRANULE_LOG2, 32'd31);
    random_traffic(40);
    drain_results();

    // long receiver hold-off while requests keep coming
    write_reg(CFG_GRANULE_LOG2, 32'd10);
    write_reg(CFG_REGION_LENGTH, 32'h0004_0000);
    hold_rx = 1;
    random_traffic(180);
    drain_results();

    // small range, frequent exhaustion
    write_reg(CFG_REGION_START, $urandom());
    write_reg(CFG_REGION_LENGTH, 32'h0000_8000);
    write_reg(CFG_GRANULE_LOG2, 32'd12);
    random_traffic(130);

    drain_results();
    if (fail_count == 0) $display("first_fit_region_allocator_core: match");
    else $display("first_fit_region_allocator_core: mismatch");
    $finish;
  end

endmodule
